// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define FTSCH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define FTSCH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FTSCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ftsch_pkg.sv -----
// Package for the fixed-priority tick scheduler: widths, register codes, cell control.
`default_nettype none

package ftsch_pkg;

   localparam int DEF_MAX_TASKS  = 4;
   localparam int DEF_TIME_WIDTH = 16;

   localparam int FIELD_WIDTH = 16;
   localparam int COUNT_WIDTH = 3;
   localparam int CSR_WIDTH   = 64;
   localparam int RUN_WIDTH   = 3;
   localparam int MASK_WIDTH  = 4;

   typedef enum logic [1:0] {
      CSR_TASK_COUNT     = 2'd0,
      CSR_MINOR_FRAME    = 2'd1,
      CSR_TASK_BUDGETS   = 2'd2,
      CSR_TASK_DEADLINES = 2'd3
   } csr_index_type;

   localparam logic [COUNT_WIDTH-1:0] RST_TASK_COUNT     = 3'd1;
   localparam logic [FIELD_WIDTH-1:0] RST_MINOR_FRAME    = 16'd1;
   localparam logic [CSR_WIDTH-1:0]   RST_TASK_BUDGETS   = 64'd0;
   localparam logic [CSR_WIDTH-1:0]   RST_TASK_DEADLINES = 64'h0001_0001_0001_0001;

   // Per-slot control handed to every cell.
   typedef struct packed {
      logic step;         // a tick slot elapses this cycle
      logic frame_start;  // slot is the first of a minor frame
      logic active;       // cell index below the task count
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ftsch_req_if.sv -----
// Input channel: one tick item per handshake.
`default_nettype none

interface ftsch_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink (input valid, input tick, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ftsch_rsp_if.sv -----
// Result channel: slot grant, release and miss masks, frame start flag.
`default_nettype none

interface ftsch_rsp_if
   import ftsch_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [RUN_WIDTH-1:0]  run_task;
   logic [MASK_WIDTH-1:0] release_mask;
   logic [MASK_WIDTH-1:0] miss_mask;
   logic                  frame_start;

   modport source (output valid, output run_task, output release_mask,
                   output miss_mask, output frame_start, input ready);
   modport sink (input valid, input run_task, input release_mask,
                 input miss_mask, input frame_start, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ftsch_cell.sv -----
// One task cell: remaining work, deadline phase, release and grant chain stage.
`default_nettype none

module ftsch_cell
   import ftsch_pkg::*;
#(
   parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  cell_ctl_type          ctl,
   input  wire [TIME_WIDTH-1:0]  frame_len,
   input  wire [TIME_WIDTH-1:0]  budget,
   input  wire [TIME_WIDTH-1:0]  deadline,
   input  wire                   grant_in,   // no higher-priority task has work
   output logic                  grant_out,
   output logic                  run,
   output logic                  released,
   output logic                  missed
);

   logic [TIME_WIDTH-1:0] work_ff, work_in;
   logic [TIME_WIDTH-1:0] phase_ff, phase_in;
   logic [TIME_WIDTH-1:0] work_eff;
   logic [TIME_WIDTH:0]   phase_sum;
   logic [TIME_WIDTH:0]   deadline_ext;
   logic                  has_work;

   always_comb begin
      released  = ctl.frame_start && ctl.active && (phase_ff == '0);
      missed    = released && (work_ff != '0);
      work_eff  = released ? budget : work_ff;
      has_work  = ctl.active && (work_eff != '0);
      run       = grant_in && has_work;
      grant_out = grant_in && !has_work;

      // Phase advances by one frame and wraps by a single subtraction.
      phase_sum    = {1'b0, phase_ff} + {1'b0, frame_len};
      deadline_ext = {1'b0, deadline};
      if (phase_sum >= deadline_ext) begin
         phase_sum = phase_sum - deadline_ext;
      end

      work_in  = work_ff;
      phase_in = phase_ff;
      if (ctl.step) begin
         work_in = run ? (work_eff - 1'b1) : work_eff;
         if (ctl.frame_start) begin
            phase_in = phase_sum[TIME_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff  <= '0;
         phase_ff <= '0;
      end else begin
         work_ff  <= work_in;
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fixed_priority_tick_scheduler.sv -----
// Top level: fixed-priority, slot-based task scheduler with a row of task cells.
//
// Usage:
//   req carries one tick item per handshake (valid & ready). An item with tick
//   high is one time slot and yields exactly one result on rsp; an item with
//   tick low is taken and changes nothing.
//   rsp gives run_task (0 idle, k = task k-1), release_mask, miss_mask and
//   frame_start for the slot.
//   The result is registered and shows on rsp in the cycle after the
//   tick is accepted. The block takes one tick per cycle while rsp does not
//   stall, set by the single pass through the grant chain of the task cells.
//   When rsp stalls, the result register holds and req.ready stays high only
//   if the waiting result is taken in the same cycle.
//   csr writes (index 0 task count, 1 minor frame, 2 budgets, 3 deadlines)
//   take effect at the next slot and are meant for idle periods.
//   Reset (synchronous) restores the register defaults, clears all work,
//   phases and the slot counter, so the first slot releases every active task.
`default_nettype none

module fixed_priority_tick_scheduler
   import ftsch_pkg::*;
#(
   parameter int MAX_TASKS  = DEF_MAX_TASKS,
   parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
   input  wire                   clock,
   input  wire                   reset,
   ftsch_req_if.sink             req,
   ftsch_rsp_if.source           rsp,
   input  wire                   csr_write_enable,
   input  csr_index_type         csr_index,
   input  wire [CSR_WIDTH-1:0]   csr_write_data
);

   `include "assert_macros.svh"

   logic [COUNT_WIDTH-1:0] task_count_ff;
   logic [FIELD_WIDTH-1:0] minor_frame_ff;
   logic [CSR_WIDTH-1:0]   budgets_ff;
   logic [CSR_WIDTH-1:0]   deadlines_ff;

   logic [TIME_WIDTH-1:0]  slot_ff, slot_in;
   logic [TIME_WIDTH:0]    slot_sum;
   logic [TIME_WIDTH-1:0]  frame_len;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RUN_WIDTH-1:0]   run_task_ff, run_task_in;
   logic [MASK_WIDTH-1:0]  release_ff, release_in;
   logic [MASK_WIDTH-1:0]  miss_ff, miss_in;
   logic                   frame_start_ff;

   logic                   take;
   logic                   step;
   logic                   frame_start;

   logic [MAX_TASKS:0]     grant;
   logic [MAX_TASKS-1:0]   run_vec;
   logic [MAX_TASKS-1:0]   rel_vec;
   logic [MAX_TASKS-1:0]   miss_vec;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff  <= RST_TASK_COUNT;
         minor_frame_ff <= RST_MINOR_FRAME;
         budgets_ff     <= RST_TASK_BUDGETS;
         deadlines_ff   <= RST_TASK_DEADLINES;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TASK_COUNT:     task_count_ff  <= csr_write_data[COUNT_WIDTH-1:0];
            CSR_MINOR_FRAME:    minor_frame_ff <= csr_write_data[FIELD_WIDTH-1:0];
            CSR_TASK_BUDGETS:   budgets_ff     <= csr_write_data;
            CSR_TASK_DEADLINES: deadlines_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Handshake and slot counter
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;
   assign step      = take && req.tick;

   always_comb begin
      frame_len = (minor_frame_ff[TIME_WIDTH-1:0] == '0) ?
                  TIME_WIDTH'(1) : minor_frame_ff[TIME_WIDTH-1:0];
      frame_start = (slot_ff == '0);
      slot_sum    = {1'b0, slot_ff} + (TIME_WIDTH+1)'(1);
      // counter past the frame end (after a write) also wraps here
      slot_in = slot_ff;
      if (step) begin
         slot_in = (slot_sum >= {1'b0, frame_len}) ? '0 : slot_sum[TIME_WIDTH-1:0];
      end
   end

   // Row of task cells, index order is priority order
   assign grant[0] = 1'b1;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      cell_ctl_type ctl;

      assign ctl.step        = step;
      assign ctl.frame_start = frame_start;
      assign ctl.active      = (COUNT_WIDTH'(i) < task_count_ff);

      ftsch_cell #(
         .TIME_WIDTH (TIME_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .frame_len (frame_len),
         .budget    (budgets_ff[i*FIELD_WIDTH +: TIME_WIDTH]),
         .deadline  (deadlines_ff[i*FIELD_WIDTH +: TIME_WIDTH]),
         .grant_in  (grant[i]),
         .grant_out (grant[i+1]),
         .run       (run_vec[i]),
         .released  (rel_vec[i]),
         .missed    (miss_vec[i])
      );
   end

   always_comb begin
      run_task_in = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (run_vec[i]) begin
            run_task_in = RUN_WIDTH'(i + 1);
         end
      end
      release_in = MASK_WIDTH'(rel_vec);
      miss_in    = MASK_WIDTH'(miss_vec);

      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         run_task_ff    <= run_task_in;
         release_ff     <= release_in;
         miss_ff        <= miss_in;
         frame_start_ff <= frame_start;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.run_task     = run_task_ff;
   assign rsp.release_mask = release_ff;
   assign rsp.miss_mask    = miss_ff;
   assign rsp.frame_start  = frame_start_ff;

   `FTSCH_ASSERT(a_grant_onehot, clock, reset, $onehot0(run_vec), "more than one task granted")
   `FTSCH_ASSERT_IMPL(a_miss_in_release, clock, reset, rsp.valid,
      (rsp.miss_mask & ~rsp.release_mask) == '0, "miss flagged on a task not released")
   `FTSCH_ASSERT_IMPL(a_release_at_frame, clock, reset, rsp.valid && (rsp.release_mask != '0),
      rsp.frame_start, "release outside a frame start")
   `FTSCH_ASSERT_NEXT(a_tick_gives_item, clock, reset, step, rsp.valid,
      "accepted tick produced no item")

endmodule

`default_nettype wire
